[src/ocp_pkg.sv]
// ----------------------------------------------------------------------------
// Orbit camera pose package
// Shared constants, kind codes, the CORDIC arctangent table and the types
// that pass between the sequencer and the CORDIC unit.
// ----------------------------------------------------------------------------
package ocp_pkg;

    // Number of CORDIC iterations per sine/cosine evaluation (8 to 24).
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int STEP_W           = $clog2(CORDIC_STEPS);
    localparam int TABLE_IDX_W      = $clog2(CORDIC_TABLE_LEN);

    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int TRIG_W   = 32;
    localparam int CX_W     = 34;
    localparam int CZ_W     = 33;

    // 0.607252935 in Q2.30, the reciprocal of the CORDIC gain.
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_ORBIT = 2'd1;
    localparam logic [1:0] KIND_MOVE  = 2'd2;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] nsin_v;
    } t_trig;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cor_stat;

    // atan(2^-i) as a 32-bit binary angle.
    function automatic logic signed [CZ_W-1:0] atan_entry(
        input logic [TABLE_IDX_W-1:0] idx
    );
        logic signed [CZ_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 33'sd536870912;
                5'd1:    v = 33'sd316933406;
                5'd2:    v = 33'sd167458907;
                5'd3:    v = 33'sd85004756;
                5'd4:    v = 33'sd42667331;
                5'd5:    v = 33'sd21354465;
                5'd6:    v = 33'sd10679838;
                5'd7:    v = 33'sd5340245;
                5'd8:    v = 33'sd2670163;
                5'd9:    v = 33'sd1335087;
                5'd10:   v = 33'sd667544;
                5'd11:   v = 33'sd333772;
                5'd12:   v = 33'sd166886;
                5'd13:   v = 33'sd83443;
                5'd14:   v = 33'sd41722;
                5'd15:   v = 33'sd20861;
                5'd16:   v = 33'sd10430;
                5'd17:   v = 33'sd5215;
                5'd18:   v = 33'sd2608;
                5'd19:   v = 33'sd1304;
                5'd20:   v = 33'sd652;
                5'd21:   v = 33'sd326;
                5'd22:   v = 33'sd163;
                5'd23:   v = 33'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[src/ocp_if.sv]
// ----------------------------------------------------------------------------
// Orbit camera pose channels
// Valid/ready channels for the request word and the pose result word.
// ----------------------------------------------------------------------------
interface ocp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           kind;
    logic signed [ocp_pkg::ANGLE_W-1:0]   elevation;
    logic signed [ocp_pkg::ANGLE_W-1:0]   azimuth;
    logic [ocp_pkg::RADIUS_W-1:0]         radius;
    logic signed [ocp_pkg::COORD_W-1:0]   forward_move;
    logic signed [ocp_pkg::COORD_W-1:0]   side_move;
    logic signed [ocp_pkg::COORD_W-1:0]   load_x;
    logic signed [ocp_pkg::COORD_W-1:0]   load_y;
    logic signed [ocp_pkg::COORD_W-1:0]   load_z;

    modport source (
        output valid, kind, elevation, azimuth, radius, forward_move, side_move,
               load_x, load_y, load_z,
        input  ready
    );
    modport sink (
        input  valid, kind, elevation, azimuth, radius, forward_move, side_move,
               load_x, load_y, load_z,
        output ready
    );
endinterface

interface ocp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ocp_pkg::COORD_W-1:0] pos_x;
    logic signed [ocp_pkg::COORD_W-1:0] pos_y;
    logic signed [ocp_pkg::COORD_W-1:0] pos_z;
    logic signed [ocp_pkg::COORD_W-1:0] target_x;
    logic signed [ocp_pkg::COORD_W-1:0] target_y;
    logic signed [ocp_pkg::COORD_W-1:0] target_z;
    logic                               saturated;

    modport source (
        output valid, pos_x, pos_y, pos_z, target_x, target_y, target_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, target_x, target_y, target_z, saturated,
        output ready
    );
endinterface

[src/ocp_cordic.sv]
// ----------------------------------------------------------------------------
// Orbit camera pose CORDIC
// Rotation-mode CORDIC giving sine, cosine and negated sine in Q2.30 of a
// 16-bit binary angle, one iteration per clock.
// ----------------------------------------------------------------------------
module ocp_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ocp_pkg::ANGLE_W-1:0]  i_angle,
    output ocp_pkg::t_trig                      o_trig,
    output ocp_pkg::t_cor_stat                  o_stat
);
    import ocp_pkg::*;

    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic signed [CZ_W-1:0] r_z;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;
    logic                   r_flip;

    logic                   w_flip_in;
    logic [31:0]            w_u;
    logic signed [CZ_W-1:0] w_z0;
    logic signed [CX_W-1:0] w_dx;
    logic signed [CX_W-1:0] w_dy;
    logic signed [CZ_W-1:0] w_atan;
    logic signed [CX_W-1:0] w_neg_x;
    logic signed [CX_W-1:0] w_neg_y;

    always_comb begin
        // Angles in the second and third quadrant are turned by a half circle.
        w_flip_in = i_angle[ANGLE_W-1] ^ i_angle[ANGLE_W-2];
        w_u       = {i_angle[ANGLE_W-1] ^ w_flip_in, i_angle[ANGLE_W-2:0], 16'h0000};
        w_z0      = CZ_W'($signed(w_u));
        w_dx      = r_y >>> r_step;
        w_dy      = r_x >>> r_step;
        w_atan    = atan_entry(TABLE_IDX_W'(r_step));
        w_neg_x   = -r_x;
        w_neg_y   = -r_y;
    end

    assign o_trig.cos_v  = r_flip ? w_neg_x[TRIG_W-1:0] : r_x[TRIG_W-1:0];
    assign o_trig.sin_v  = r_flip ? w_neg_y[TRIG_W-1:0] : r_y[TRIG_W-1:0];
    assign o_trig.nsin_v = r_flip ? r_y[TRIG_W-1:0] : w_neg_y[TRIG_W-1:0];
    assign o_stat.busy   = r_busy;
    assign o_stat.done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // Done is raised for one cycle after the last iteration.
            r_done <= !i_start && r_busy && (r_step == STEP_W'(CORDIC_STEPS - 1));
            if (i_start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= w_z0;
                r_flip <= w_flip_in;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

endmodule

[src/orbit_camera_pose_unit_top.sv]
// ----------------------------------------------------------------------------
// Orbit camera pose unit
// Keeps a target point, a camera position and an orbit radius in Q16.16 and
// updates them per request word: load, orbit placement or move.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Word contents
//  i_in     in   valid/ready    kind, elevation, azimuth, radius, forward_move,
//                               side_move, load_x, load_y, load_z
//  o_out    out  valid/ready    pos_x/y/z, target_x/y/z, saturated
//
// A load word, or a word of the unused kind, goes from acceptance straight
// to the S_DONE state. An orbit or move word runs the CORDIC unit twice,
// once for elevation and once for azimuth, and then streams five (orbit) or
// seven (move) products through the single 32x32 multiplier, one per cycle.
// The CORDIC iteration loop takes most of the time of such a word.
// i_in.ready is high only while no word is in progress. A finished result
// sits in the output register until taken; the next word may be accepted
// meanwhile, but its own result waits until the register is free.
// Reset is synchronous and active low; it clears the pose, the radius and
// all control state.
// ----------------------------------------------------------------------------
module orbit_camera_pose_unit_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ocp_in_if.sink     i_in,
    ocp_out_if.source  o_out
);
    import ocp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EL,
        S_AZ,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] val;
        logic                      clip;
    } t_sat;

    // Product schedule. The two direction terms come first; the later
    // products use them once they have been rounded back into registers.
    localparam logic [2:0] OP_DIR1   = 3'd0;
    localparam logic [2:0] OP_DIR2   = 3'd1;
    localparam logic [2:0] OP_AX_X   = 3'd2;
    localparam logic [2:0] OP_AX_Y   = 3'd3;
    localparam logic [2:0] OP_AX_Z   = 3'd4;
    localparam logic [2:0] OP_SIDE_X = 3'd5;
    localparam logic [2:0] OP_SIDE_Z = 3'd6;
    localparam logic [2:0] OP_LAST_ORBIT = OP_AX_Z;
    localparam logic [2:0] OP_LAST_MOVE  = OP_SIDE_Z;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [63:0]       ROUND_Q30 = 64'sd536870912;
    localparam logic [RADIUS_W-1:0]      ONE_Q16   = 31'd65536;
    localparam logic signed [34:0]       SAT_MAX   = 35'sd2147483647;
    localparam logic signed [34:0]       SAT_MIN   = -35'sd2147483648;

    function automatic t_sat sat32(input logic signed [34:0] v);
        t_sat s;
        begin
            if (v > SAT_MAX) begin
                s.val  = SAT_MAX[COORD_W-1:0];
                s.clip = 1'b1;
            end else if (v < SAT_MIN) begin
                s.val  = SAT_MIN[COORD_W-1:0];
                s.clip = 1'b1;
            end else begin
                s.val  = v[COORD_W-1:0];
                s.clip = 1'b0;
            end
            return s;
        end
    endfunction

    t_state r_state;

    // Pose state.
    logic signed [COORD_W-1:0] r_tgt [3];
    logic signed [COORD_W-1:0] r_cam [3];
    logic [RADIUS_W-1:0]       r_radius;

    // Word being worked on.
    logic [1:0]                r_kind;
    logic signed [ANGLE_W-1:0] r_az;
    logic signed [COORD_W-1:0] r_f;
    logic signed [COORD_W-1:0] r_s;
    logic                      r_f_nz;
    logic                      r_s_nz;
    logic                      r_sat;

    // Trigonometric values, direction terms and the multiplier register.
    logic signed [TRIG_W-1:0]  r_se;
    logic signed [TRIG_W-1:0]  r_ce;
    logic signed [TRIG_W-1:0]  r_nse;
    logic signed [TRIG_W-1:0]  r_sa;
    logic signed [TRIG_W-1:0]  r_ca;
    logic signed [TRIG_W-1:0]  r_nsa;
    logic signed [TRIG_W-1:0]  r_d1;
    logic signed [TRIG_W-1:0]  r_d2;
    logic signed [63:0]        r_prod;
    logic [2:0]                r_op;

    // Output register.
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_o_pos [3];
    logic signed [COORD_W-1:0] r_o_tgt [3];
    logic                      r_o_sat;

    logic                      w_in_acc;
    logic                      w_cor_start;
    logic signed [ANGLE_W-1:0] w_cor_angle;
    t_trig                     w_trig;
    t_cor_stat                 w_cor_stat;

    logic                      w_orbit;
    logic [2:0]                w_last;
    logic [2:0]                w_ap;
    logic signed [COORD_W-1:0] w_a;
    logic signed [TRIG_W-1:0]  w_b;
    logic signed [63:0]        w_rsum;
    logic signed [33:0]        w_rnd;
    logic [1:0]                w_axis;
    logic                      w_gate;
    logic                      w_sub;
    logic signed [34:0]        w_sum_t;
    logic signed [34:0]        w_sum_c;
    t_sat                      w_sat_t;
    t_sat                      w_sat_c;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign w_cor_start = (w_in_acc && (i_in.kind == KIND_ORBIT || i_in.kind == KIND_MOVE))
                      || (r_state == S_EL && w_cor_stat.done);
    assign w_cor_angle = (r_state == S_IDLE) ? i_in.elevation : r_az;

    ocp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (w_cor_angle),
        .o_trig  (w_trig),
        .o_stat  (w_cor_stat)
    );

    // Operand selection for the product issued this cycle, and the rounding,
    // add and saturation of the product issued in the previous cycle.
    always_comb begin
        w_orbit = (r_kind == KIND_ORBIT);
        w_last  = w_orbit ? OP_LAST_ORBIT : OP_LAST_MOVE;
        w_ap    = r_op - 3'd1;

        unique case (r_op)
            OP_DIR1:   begin w_a = r_sa; w_b = r_ce;  end
            OP_DIR2:   begin w_a = r_ce; w_b = r_ca;  end
            OP_AX_X:   begin
                w_a = w_orbit ? $signed({1'b0, r_radius}) : r_f;
                w_b = r_d1;
            end
            OP_AX_Y:   begin
                w_a = w_orbit ? $signed({1'b0, r_radius}) : r_f;
                w_b = w_orbit ? r_se : r_nse;
            end
            OP_AX_Z:   begin
                w_a = w_orbit ? $signed({1'b0, r_radius}) : r_f;
                w_b = r_d2;
            end
            OP_SIDE_X: begin w_a = r_s;  w_b = r_ca;  end
            OP_SIDE_Z: begin w_a = r_s;  w_b = r_nsa; end
            default:   begin w_a = '0;   w_b = '0;    end
        endcase

        w_rsum = r_prod + ROUND_Q30;
        w_rnd  = w_rsum[63:30];

        unique case (w_ap)
            OP_AX_X, OP_SIDE_X: w_axis = AXIS_X;
            OP_AX_Y:            w_axis = AXIS_Y;
            OP_AX_Z, OP_SIDE_Z: w_axis = AXIS_Z;
            default:            w_axis = AXIS_X;
        endcase

        unique case (w_ap)
            OP_AX_X, OP_AX_Y, OP_AX_Z: w_gate = w_orbit || r_f_nz;
            OP_SIDE_X, OP_SIDE_Z:      w_gate = r_s_nz;
            default:                   w_gate = 1'b0;
        endcase

        // The orbit placement subtracts on x and z and adds on y.
        w_sub   = w_orbit && (w_axis != AXIS_Y);
        w_sum_t = w_sub ? (35'(r_tgt[w_axis]) - 35'(w_rnd))
                        : (35'(r_tgt[w_axis]) + 35'(w_rnd));
        w_sum_c = 35'(r_cam[w_axis]) + 35'(w_rnd);
        w_sat_t = sat32(w_sum_t);
        w_sat_c = sat32(w_sum_c);
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pos_x     = r_o_pos[0];
    assign o_out.pos_y     = r_o_pos[1];
    assign o_out.pos_z     = r_o_pos[2];
    assign o_out.target_x  = r_o_tgt[0];
    assign o_out.target_y  = r_o_tgt[1];
    assign o_out.target_z  = r_o_tgt[2];
    assign o_out.saturated = r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= '0;
            r_sat       <= 1'b0;
            r_radius    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_tgt[i] <= '0;
                r_cam[i] <= '0;
            end
        end else begin
            // In S_DONE a word taken here is replaced by the new result below.
            if (o_out.valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind <= i_in.kind;
                        r_az   <= i_in.azimuth;
                        r_f    <= i_in.forward_move;
                        r_s    <= i_in.side_move;
                        r_f_nz <= (i_in.forward_move != '0);
                        r_s_nz <= (i_in.side_move != '0);
                        r_sat  <= 1'b0;
                        priority if (i_in.kind == KIND_LOAD) begin
                            r_radius <= i_in.radius;
                            r_tgt[0] <= i_in.load_x;
                            r_tgt[1] <= i_in.load_y;
                            r_tgt[2] <= i_in.load_z;
                            r_state  <= S_DONE;
                        end else if (i_in.kind == KIND_ORBIT) begin
                            r_state <= S_EL;
                        end else if (i_in.kind == KIND_MOVE) begin
                            // Any nonzero move resets the orbit radius to one.
                            if (i_in.forward_move != '0 || i_in.side_move != '0) begin
                                r_radius <= ONE_Q16;
                            end
                            r_state <= S_EL;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_EL: begin
                    if (w_cor_stat.done) begin
                        r_se    <= w_trig.sin_v;
                        r_ce    <= w_trig.cos_v;
                        r_nse   <= w_trig.nsin_v;
                        r_state <= S_AZ;
                    end
                end
                S_AZ: begin
                    if (w_cor_stat.done) begin
                        r_sa    <= w_trig.sin_v;
                        r_ca    <= w_trig.cos_v;
                        r_nsa   <= w_trig.nsin_v;
                        r_op    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_op <= w_last) begin
                        r_prod <= w_a * w_b;
                    end
                    if (r_op != OP_DIR1) begin
                        if (w_ap == OP_DIR1) begin
                            r_d1 <= w_rnd[TRIG_W-1:0];
                        end else if (w_ap == OP_DIR2) begin
                            r_d2 <= w_rnd[TRIG_W-1:0];
                        end else if (w_gate) begin
                            if (w_orbit) begin
                                r_cam[w_axis] <= w_sat_t.val;
                                r_sat         <= r_sat | w_sat_t.clip;
                            end else begin
                                r_tgt[w_axis] <= w_sat_t.val;
                                r_cam[w_axis] <= w_sat_c.val;
                                r_sat         <= r_sat | w_sat_t.clip | w_sat_c.clip;
                            end
                        end
                    end
                    if (r_op == w_last + 3'd1) begin
                        r_state <= S_DONE;
                    end
                    r_op <= r_op + 3'd1;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        for (int i = 0; i < 3; i++) begin
                            r_o_pos[i] <= r_cam[i];
                            r_o_tgt[i] <= r_tgt[i];
                        end
                        r_o_sat     <= r_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The shared CORDIC unit is never restarted while it is iterating.
    a_cor_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_start |-> !w_cor_stat.busy)
        else $error("CORDIC started while busy");

    // A CORDIC completion is only ever seen while the sequencer waits for it.
    a_cor_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_stat.done |-> (r_state == S_EL || r_state == S_AZ))
        else $error("CORDIC completion outside an angle phase");

    // A load word leaves the camera position untouched.
    a_load_keeps_cam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.kind == KIND_LOAD) |=>
            ($stable(r_cam[0]) && $stable(r_cam[1]) && $stable(r_cam[2])))
        else $error("load word changed the camera position");

    // Products are only streamed for orbit and move words.
    a_mul_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_kind == KIND_ORBIT || r_kind == KIND_MOVE))
        else $error("product phase entered for a word without products");

    // Each word starts with a clean saturation flag.
    a_sat_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !r_sat)
        else $error("saturation flag carried over between words");

endmodule
